// File: hw/rtl/bilup_pkg.sv
`timescale 1ns / 1ps

package bilup_pkg;

    localparam int SRC_DIM    = 32;
    localparam int DST_DIM    = 64;
    localparam int FRAC_BITS  = 8;

    localparam int SRC_IDX_W  = $clog2(SRC_DIM);
    localparam int SRC_ADDR_W = 2 * SRC_IDX_W;
    localparam int SRC_DEPTH  = SRC_DIM * SRC_DIM;
    localparam int DST_IDX_W  = $clog2(DST_DIM);
    localparam int SRC_SIZE_W = 6;
    localparam int DST_SIZE_W = 7;
    localparam int STEP_W     = 8;
    localparam int PIX_W      = 8;
    localparam int POS_W      = DST_IDX_W + STEP_W;
    localparam int INT_W      = POS_W - FRAC_BITS;
    localparam int WGT_W      = FRAC_BITS + 1;
    localparam int WGT2_W     = 2 * FRAC_BITS + 1;
    localparam int ACC_W      = PIX_W + 2 * FRAC_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd5;

    typedef struct packed {
        logic [SRC_IDX_W-1:0] base;
        logic [SRC_IDX_W-1:0] next;
        logic [FRAC_BITS-1:0] frac;
    } axis_map_t;

    // last valid source index for a programmed size
    function automatic logic [SRC_IDX_W-1:0] src_last(input logic [SRC_SIZE_W-1:0] v);
        logic [SRC_IDX_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > SRC_SIZE_W'(SRC_DIM))
            r = SRC_IDX_W'(SRC_DIM - 1);
        else
            r = SRC_IDX_W'(v - 1'b1);
        return r;
    endfunction

    // last valid destination index for a programmed size
    function automatic logic [DST_IDX_W-1:0] dst_last(input logic [DST_SIZE_W-1:0] v);
        logic [DST_IDX_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > DST_SIZE_W'(DST_DIM))
            r = DST_IDX_W'(DST_DIM - 1);
        else
            r = DST_IDX_W'(v - 1'b1);
        return r;
    endfunction

    function automatic axis_map_t map_axis(
        input logic [DST_IDX_W-1:0] c,
        input logic [STEP_W-1:0]    step,
        input logic [SRC_IDX_W-1:0] last
    );
        logic [POS_W-1:0] p;
        logic [INT_W-1:0] b;
        axis_map_t        m;
        p      = POS_W'(c) * POS_W'(step);
        b      = p[POS_W-1:FRAC_BITS];
        m.frac = p[FRAC_BITS-1:0];
        if (b > INT_W'(last))
            m.base = last;
        else
            m.base = b[SRC_IDX_W-1:0];
        m.next = (m.base == last) ? last : m.base + 1'b1;
        return m;
    endfunction

endpackage

// File: hw/rtl/bilup_ram.sv
`timescale 1ns / 1ps

module bilup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/bilinear_image_upscaler_unit.sv
`timescale 1ns / 1ps

// Bilinear upscaler for a source image of up to 32x32 8-bit pixels held in a
// 1024-entry memory. A load transfer writes one source pixel. A render
// transfer produces one destination row, one output transfer per column, the
// last marked by row_last; a row at or past dest_height produces nothing.
// Each destination pixel needs four neighbor reads through the memory's
// single read port, each followed by one multiply-accumulate. The input is
// taken again once the last pixel sits in the output register.

module bilinear_image_upscaler_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bilup_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bilup_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [bilup_pkg::SRC_IDX_W-1:0]   load_col,
    input  logic [bilup_pkg::SRC_IDX_W-1:0]   load_row,
    input  logic [bilup_pkg::PIX_W-1:0]       load_value,
    input  logic [bilup_pkg::DST_IDX_W-1:0]   render_row,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bilup_pkg::DST_IDX_W-1:0]   out_col,
    output logic [bilup_pkg::DST_IDX_W-1:0]   out_row,
    output logic [bilup_pkg::PIX_W-1:0]       pixel_value,
    output logic                              pixel_bit,
    output logic                              row_last
);

    import bilup_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROW  = 3'd1;
    localparam logic [2:0] S_COL  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [SRC_SIZE_W-1:0] src_w_reg;
    logic [SRC_SIZE_W-1:0] src_h_reg;
    logic [DST_SIZE_W-1:0] dst_w_reg;
    logic [DST_SIZE_W-1:0] dst_h_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [PIX_W-1:0]      thr_reg;

    logic [SRC_IDX_W-1:0]  sw_last;
    logic [SRC_IDX_W-1:0]  sh_last;
    logic [DST_IDX_W-1:0]  dw_last;
    logic [DST_IDX_W-1:0]  dh_last;

    logic [2:0]            state_reg, state_next;
    logic                  prod_valid_reg, prod_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DST_IDX_W-1:0]  row_reg, row_next;
    logic [DST_IDX_W-1:0]  col_reg, col_next;
    axis_map_t             rmap_reg, rmap_next;
    axis_map_t             cmap_reg, cmap_next;
    logic [1:0]            phase_reg, phase_next;
    logic [WGT2_W-1:0]     w_reg, w_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;

    logic [DST_IDX_W-1:0]  out_col_reg, out_col_next;
    logic [DST_IDX_W-1:0]  out_row_reg, out_row_next;
    logic [PIX_W-1:0]      out_pix_reg, out_pix_next;
    logic                  out_bit_reg, out_bit_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_xfer;
    logic                  load_we;
    logic [SRC_ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]      rd_data;
    logic [WGT_W-1:0]      wr_sel;
    logic [WGT_W-1:0]      wc_sel;
    logic                  slot_free;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SRC_SIZE_W'(16);
            src_h_reg <= SRC_SIZE_W'(16);
            dst_w_reg <= DST_SIZE_W'(32);
            dst_h_reg <= DST_SIZE_W'(32);
            step_reg  <= STEP_W'(128);
            thr_reg   <= PIX_W'(128);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_w_reg <= cfg_data[SRC_SIZE_W-1:0];
                CFG_SRC_HEIGHT: src_h_reg <= cfg_data[SRC_SIZE_W-1:0];
                CFG_DST_WIDTH:  dst_w_reg <= cfg_data[DST_SIZE_W-1:0];
                CFG_DST_HEIGHT: dst_h_reg <= cfg_data[DST_SIZE_W-1:0];
                CFG_STEP:       step_reg  <= cfg_data[STEP_W-1:0];
                CFG_THRESHOLD:  thr_reg   <= cfg_data[PIX_W-1:0];
                default:        ;
            endcase
        end
    end

    assign sw_last = src_last(src_w_reg);
    assign sh_last = src_last(src_h_reg);
    assign dw_last = dst_last(dst_w_reg);
    assign dh_last = dst_last(dst_h_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign load_we   = in_xfer && (op == OP_LOAD);
    assign slot_free = !out_valid_reg || out_ready;

    bilup_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SRC_DEPTH)
    ) u_src_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr ({load_row, load_col}),
        .wdata (load_value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // neighbor order: top-left, top-right, bottom-left, bottom-right
    always_comb
    begin
        unique case (phase_reg)
            2'd0:
            begin
                rd_addr = {rmap_reg.base, cmap_reg.base};
                wr_sel  = WGT_W'(1 << FRAC_BITS) - WGT_W'(rmap_reg.frac);
                wc_sel  = WGT_W'(1 << FRAC_BITS) - WGT_W'(cmap_reg.frac);
            end
            2'd1:
            begin
                rd_addr = {rmap_reg.base, cmap_reg.next};
                wr_sel  = WGT_W'(1 << FRAC_BITS) - WGT_W'(rmap_reg.frac);
                wc_sel  = WGT_W'(cmap_reg.frac);
            end
            2'd2:
            begin
                rd_addr = {rmap_reg.next, cmap_reg.base};
                wr_sel  = WGT_W'(rmap_reg.frac);
                wc_sel  = WGT_W'(1 << FRAC_BITS) - WGT_W'(cmap_reg.frac);
            end
            default:
            begin
                rd_addr = {rmap_reg.next, cmap_reg.next};
                wr_sel  = WGT_W'(rmap_reg.frac);
                wc_sel  = WGT_W'(cmap_reg.frac);
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        prod_valid_next = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        row_next        = row_reg;
        col_next        = col_reg;
        rmap_next       = rmap_reg;
        cmap_next       = cmap_reg;
        phase_next      = phase_reg;
        w_next          = w_reg;
        acc_next        = acc_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_pix_next    = out_pix_reg;
        out_bit_next    = out_bit_reg;
        out_last_next   = out_last_reg;

        if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(ACC_W'(rd_data) * ACC_W'(w_reg));
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (op == OP_RENDER))
                begin
                    row_next   = render_row;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                rmap_next = map_axis(row_reg, step_reg, sh_last);
                col_next  = '0;
                state_next = (row_reg > dh_last) ? S_IDLE : S_COL;
            end
            S_COL:
            begin
                cmap_next  = map_axis(col_reg, step_reg, sw_last);
                acc_next   = '0;
                phase_next = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                w_next          = WGT2_W'(WGT2_W'(wr_sel) * WGT2_W'(wc_sel));
                prod_valid_next = 1'b1;
                phase_next      = phase_reg + 1'b1;
                if (phase_reg == 2'd3)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = col_reg;
                    out_row_next   = row_reg;
                    out_pix_next   = acc_reg[ACC_W-1 -: PIX_W];
                    out_bit_next   = acc_reg[ACC_W-1 -: PIX_W] > thr_reg;
                    out_last_next  = (col_reg == dw_last);
                    col_next       = col_reg + 1'b1;
                    state_next     = (col_reg == dw_last) ? S_IDLE : S_COL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        rmap_reg     <= rmap_next;
        cmap_reg     <= cmap_next;
        phase_reg    <= phase_next;
        w_reg        <= w_next;
        acc_reg      <= acc_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_pix_reg  <= out_pix_next;
        out_bit_reg  <= out_bit_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_col     = out_col_reg;
    assign out_row     = out_row_reg;
    assign pixel_value = out_pix_reg;
    assign pixel_bit   = out_bit_reg;
    assign row_last    = out_last_reg;

    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_last |-> out_col == dw_last)
        else $error("row_last on a column other than the last");

    a_render_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_RENDER |=> state_reg == S_ROW)
        else $error("render transfer did not start a row");

    a_prod_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> $past(state_reg) == S_RD)
        else $error("accumulate without a preceding memory read");

endmodule
